FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check macros, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every enabled edge
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
// consequent must hold at the edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m: check failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// types, constants and arithmetic helpers of the sensor compensation pipeline
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int FRONT_STAGES = 16;
  localparam int DIV_BITS     = 64;
  localparam int BACK_STAGES  = 6;

  localparam logic [63:0] FINE_PRESS_OFS = 64'd128000;
  localparam logic [63:0] PRESS_FULL     = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE    = 64'd3125;
  localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] FINE_HUM_OFS   = 32'd76800;
  localparam logic [31:0] HUM_MAX        = 32'd419430400;
  localparam logic [31:0] HUM_Y_OFS      = 32'd2097152;
  localparam logic [31:0] HUM_RND_X      = 32'd16384;
  localparam logic [31:0] HUM_H3_OFS     = 32'd32768;
  localparam logic [31:0] HUM_RND_Y      = 32'd8192;
  localparam logic [31:0] TEMP_SCALE     = 32'd5;
  localparam logic [31:0] TEMP_RND       = 32'd128;

  typedef enum logic [2:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL_A   = 3'd4,
    REG_HUM_CAL_B   = 3'd5
  } reg_idx_t;

  // decoded calibration, all as two's complement patterns
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  // partial products of a 64-bit wrapping multiply
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } pp_t;

  // finished fields that ride along with the pressure path
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
  } res_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx64(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = 64'(a[31:0]) * 64'(b[31:0]);
    r.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    return p.ll + {p.cr, 32'h0};
  endfunction

  function automatic cal_t cal_decode(input logic [47:0] tc, input logic [47:0] pa,
                                      input logic [47:0] pb, input logic [47:0] pc,
                                      input logic [39:0] ha, input logic [31:0] hb);
    cal_t c;
    c.t1 = {16'h0, tc[15:0]};
    c.t2 = sx16(tc[31:16]);
    c.t3 = sx16(tc[47:32]);
    c.p1 = {48'h0, pa[15:0]};
    c.p2 = sx64(sx16(pa[31:16]));
    c.p3 = sx64(sx16(pa[47:32]));
    c.p4 = sx64(sx16(pb[15:0]));
    c.p5 = sx64(sx16(pb[31:16]));
    c.p6 = sx64(sx16(pb[47:32]));
    c.p7 = sx64(sx16(pc[15:0]));
    c.p8 = sx64(sx16(pc[31:16]));
    c.p9 = sx64(sx16(pc[47:32]));
    c.h1 = {24'h0, ha[7:0]};
    c.h2 = sx16(ha[23:8]);
    c.h3 = {24'h0, ha[31:24]};
    c.h6 = {{24{ha[39]}}, ha[39:32]};
    c.h4 = sx16(hb[15:0]);
    c.h5 = sx16(hb[31:16]);
    return c;
  endfunction

endpackage

FILE: hdl/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// temperature, humidity and the pressure dividend / divisor, 17 stages
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  logic [15:0] raw_h,
  input  cal_t        cal,
  output logic        fr_valid,
  output logic [63:0] fr_num,
  output logic [63:0] fr_den,
  output res_t        fr_res
);

  typedef struct packed {
    logic [19:0] adc_t, adc_p;
    logic [15:0] adc_h;
    logic [31:0] ta, d, xa, a, dd, b0, fine, temp, hv;
    logic [63:0] v1;
    pp_t  [2:0]  pp;
    logic [63:0] vv, v1p5, v1p2, vvp6, vvp3, v2, v1b, s, num0, vp1, num, den;
    logic [31:0] m1, m2, m3, x, ya, yb, y0, y1, y2m, y, vm, ha, aa, q;
    logic [16:0] hum;
  } front_t;

  function automatic front_t front_step(input int k, input front_t p, input cal_t c);
    front_t s;
    logic [31:0] hv2;
    s   = p;
    hv2 = p.vm - sra32(p.q, 4);
    case (k)
      1: begin
        s.ta = 32'(p.adc_t >> 3) - (c.t1 << 1);
        s.d  = 32'(p.adc_t >> 4) - c.t1;
        s.xa = (32'(p.adc_h) << 14) - (c.h4 << 20);
      end
      2: begin
        s.a  = sra32(p.ta * c.t2, 11);
        s.dd = sra32(p.d * p.d, 12);
      end
      3: s.b0 = p.dd * c.t3;
      4: s.fine = p.a + sra32(p.b0, 14);
      5: begin
        s.temp = sra32(p.fine * TEMP_SCALE + TEMP_RND, 8);
        s.v1   = sx64(p.fine) - FINE_PRESS_OFS;
        s.hv   = p.fine - FINE_HUM_OFS;
      end
      6: begin
        s.pp[0] = pp_mul(p.v1, p.v1);
        s.pp[1] = pp_mul(p.v1, c.p5);
        s.pp[2] = pp_mul(p.v1, c.p2);
        s.m1    = c.h5 * p.hv;
        s.m2    = p.hv * c.h6;
        s.m3    = p.hv * c.h3;
      end
      7: begin
        s.vv   = pp_sum(p.pp[0]);
        s.v1p5 = pp_sum(p.pp[1]);
        s.v1p2 = pp_sum(p.pp[2]);
        s.x    = sra32(p.xa - p.m1 + HUM_RND_X, 15);
        s.ya   = sra32(p.m2, 10);
        s.yb   = sra32(p.m3, 11) + HUM_H3_OFS;
      end
      8: begin
        s.pp[0] = pp_mul(p.vv, c.p6);
        s.pp[1] = pp_mul(p.vv, c.p3);
        s.y0    = p.ya * p.yb;
      end
      9: begin
        s.vvp6 = pp_sum(p.pp[0]);
        s.vvp3 = pp_sum(p.pp[1]);
        s.y1   = sra32(p.y0, 10) + HUM_Y_OFS;
      end
      10: begin
        s.v2  = p.vvp6 + (p.v1p5 << 17) + (c.p4 << 35);
        s.v1b = sra64(p.vvp3, 8) + (p.v1p2 << 12);
        s.y2m = p.y1 * c.h2;
      end
      11: begin
        s.s    = PRESS_BIAS + p.v1b;
        s.num0 = ((PRESS_FULL - 64'(p.adc_p)) << 31) - p.v2;
        s.y    = sra32(p.y2m + HUM_RND_Y, 14);
      end
      12: begin
        s.pp[0] = pp_mul(p.s, c.p1);
        s.pp[1] = pp_mul(p.num0, PRESS_SCALE);
        s.vm    = p.x * p.y;
      end
      13: begin
        s.vp1 = pp_sum(p.pp[0]);
        s.num = pp_sum(p.pp[1]);
        s.ha  = sra32(p.vm, 15);
      end
      14: begin
        s.den = sra64(p.vp1, 33);
        s.aa  = p.ha * p.ha;
      end
      15: s.q = sra32(p.aa, 7) * c.h1;
      16: begin
        // clamp to zero .. full scale before dropping the fraction
        if (hv2[31]) begin
          s.hum = '0;
        end else if (hv2 > HUM_MAX) begin
          s.hum = 17'(HUM_MAX >> 12);
        end else begin
          s.hum = 17'(hv2 >> 12);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  logic   [FRONT_STAGES:0] vld_r;
  front_t                  st_r   [FRONT_STAGES+1];
  front_t                  st_nxt [FRONT_STAGES+1];

  always_comb begin
    st_nxt[0]       = '0;
    st_nxt[0].adc_t = raw_t;
    st_nxt[0].adc_p = raw_p;
    st_nxt[0].adc_h = raw_h;
  end

  for (genvar k = 1; k <= FRONT_STAGES; k++) begin : g_stage
    always_comb st_nxt[k] = front_step(k, st_r[k-1], cal);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[FRONT_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= FRONT_STAGES; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign fr_valid    = vld_r[FRONT_STAGES];
  assign fr_num      = st_r[FRONT_STAGES].num;
  assign fr_den      = st_r[FRONT_STAGES].den;
  assign fr_res.temp = st_r[FRONT_STAGES].temp;
  assign fr_res.hum  = st_r[FRONT_STAGES].hum;

endmodule

FILE: hdl/sic_div.sv
// ----------------------------------------------------------------------------
// sic_div
// pipelined signed 64-bit divide, one quotient bit per stage, truncating
// ----------------------------------------------------------------------------
module sic_div import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        dv_valid,
  input  logic [63:0] dv_num,
  input  logic [63:0] dv_den,
  input  res_t        dv_res,
  output logic        qo_valid,
  output logic [63:0] qo_quot,
  output logic        qo_zero,
  output res_t        qo_res
);

  localparam int LAST = DIV_BITS + 1;

  typedef struct packed {
    logic [64:0] rem;
    logic [63:0] quo;
    logic [63:0] ub;
    logic        neg;
    logic        zero;
    res_t        res;
  } div_t;

  logic [LAST:0] vld_r;
  div_t          st_r   [LAST+1];
  div_t          st_nxt [LAST+1];

  // prep: magnitudes and result sign
  always_comb begin
    st_nxt[0].rem  = '0;
    st_nxt[0].quo  = dv_num[63] ? (64'd0 - dv_num) : dv_num;
    st_nxt[0].ub   = dv_den[63] ? (64'd0 - dv_den) : dv_den;
    st_nxt[0].neg  = dv_num[63] ^ dv_den[63];
    st_nxt[0].zero = (dv_den == 64'd0);
    st_nxt[0].res  = dv_res;
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_bit
    logic [64:0] sh;
    logic        ge;
    assign sh = {st_r[k-1].rem[63:0], st_r[k-1].quo[63]};
    assign ge = (sh >= {1'b0, st_r[k-1].ub});
    always_comb begin
      st_nxt[k]     = st_r[k-1];
      st_nxt[k].rem = ge ? (sh - {1'b0, st_r[k-1].ub}) : sh;
      st_nxt[k].quo = {st_r[k-1].quo[62:0], ge};
    end
  end

  always_comb begin
    st_nxt[LAST]     = st_r[LAST-1];
    st_nxt[LAST].quo = st_r[LAST-1].neg ? (64'd0 - st_r[LAST-1].quo) : st_r[LAST-1].quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= LAST; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign qo_valid = vld_r[LAST];
  assign qo_quot  = st_r[LAST].quo;
  assign qo_zero  = st_r[LAST].zero;
  assign qo_res   = st_r[LAST].res;

endmodule

FILE: hdl/sic_back.sv
// ----------------------------------------------------------------------------
// sic_back
// pressure correction after the divide, output register at the end
// ----------------------------------------------------------------------------
module sic_back import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        bk_valid,
  input  logic [63:0] bk_quot,
  input  logic        bk_zero,
  input  res_t        bk_res,
  input  cal_t        cal,
  output logic        rs_valid,
  output logic [31:0] rs_press,
  output res_t        rs_res
);

  typedef struct packed {
    logic [63:0] p, ps, p8p, p9ps, t;
    pp_t         pp;
    logic [31:0] pres;
    logic        zero;
    res_t        res;
  } back_t;

  function automatic back_t back_step(input int k, input back_t p, input cal_t c);
    back_t s;
    logic [63:0] pf;
    s  = p;
    pf = sra64(p.p + sra64(p.t, 25) + sra64(p.p8p, 19), 8) + (c.p7 << 4);
    case (k)
      1: begin
        s.ps = sra64(p.p, 13);
        s.pp = pp_mul(c.p8, p.p);
      end
      2: begin
        s.p8p = pp_sum(p.pp);
        s.pp  = pp_mul(c.p9, p.ps);
      end
      3: s.p9ps = pp_sum(p.pp);
      4: s.pp = pp_mul(p.p9ps, p.ps);
      5: s.t = pp_sum(p.pp);
      6: s.pres = p.zero ? 32'd0 : pf[31:0];
      default: ;
    endcase
    return s;
  endfunction

  back_t                 bin;
  logic [BACK_STAGES:1]  vld_r;
  back_t                 st_r   [1:BACK_STAGES];
  back_t                 st_nxt [1:BACK_STAGES];

  always_comb begin
    bin      = '0;
    bin.p    = bk_quot;
    bin.zero = bk_zero;
    bin.res  = bk_res;
  end

  always_comb st_nxt[1] = back_step(1, bin, cal);

  for (genvar k = 2; k <= BACK_STAGES; k++) begin : g_stage
    always_comb st_nxt[k] = back_step(k, st_r[k-1], cal);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= BACK_STAGES; i++) st_r[i] <= st_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BACK_STAGES-1:1], bk_valid};
    end
  end

  assign rs_valid = vld_r[BACK_STAGES];
  assign rs_press = st_r[BACK_STAGES].pres;
  assign rs_res   = st_r[BACK_STAGES].res;

endmodule

FILE: hdl/sensor_integer_compensation_top.sv
// ----------------------------------------------------------------------------
// sensor_integer_compensation_top
// integer compensation of temperature, pressure and humidity samples
// ----------------------------------------------------------------------------
// One raw sample word (temperature, pressure, humidity) goes in, one
// compensated word comes out, in the same order. The pipeline takes a new
// word every cycle unless stalled. It has 17 front stages, 66 divider
// stages (prep, one per bit of the 64-bit pressure quotient, sign) and 6
// pressure correction stages, the last of which is the output register.
// A stalled output freezes the whole pipeline, so in_stall follows out_stall
// while a result waits. Calibration registers reset to 0 and must only be
// written while the pipeline is empty; indexes past the last register are
// ignored. A zero pressure divisor gives pressure 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_integer_compensation_top import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  logic [15:0] in_raw_humidity,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic [16:0] out_humidity_q22_10,
  // calibration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  // calibration registers
  logic [47:0] temp_cal_r, press_a_r, press_b_r, press_c_r;
  logic [39:0] hum_a_r;
  logic [31:0] hum_b_r;
  cal_t        cal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
      hum_a_r    <= '0;
      hum_b_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL:    temp_cal_r <= cfg_wdata;
        REG_PRESS_CAL_A: press_a_r  <= cfg_wdata;
        REG_PRESS_CAL_B: press_b_r  <= cfg_wdata;
        REG_PRESS_CAL_C: press_c_r  <= cfg_wdata;
        REG_HUM_CAL_A:   hum_a_r    <= cfg_wdata[39:0];
        REG_HUM_CAL_B:   hum_b_r    <= cfg_wdata[31:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // field split and sign extension; the user, not the block, keeps it stable while the pipeline runs
  assign cal = cal_decode(temp_cal_r, press_a_r, press_b_r, press_c_r, hum_a_r, hum_b_r);

  // global advance: everything moves unless a finished word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front: temperature, humidity, pressure dividend and divisor
  logic        fr_valid;
  logic [63:0] fr_num, fr_den;
  res_t        fr_res;

  sic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .raw_t    (in_raw_temperature),
    .raw_p    (in_raw_pressure),
    .raw_h    (in_raw_humidity),
    .cal      (cal),
    .fr_valid (fr_valid),
    .fr_num   (fr_num),
    .fr_den   (fr_den),
    .fr_res   (fr_res)
  );

  // divider: signed, truncating, finished words ride alongside
  logic        qo_valid, qo_zero;
  logic [63:0] qo_quot;
  res_t        qo_res;

  sic_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dv_valid (fr_valid),
    .dv_num   (fr_num),
    .dv_den   (fr_den),
    .dv_res   (fr_res),
    .qo_valid (qo_valid),
    .qo_quot  (qo_quot),
    .qo_zero  (qo_zero),
    .qo_res   (qo_res)
  );

  // back: second order pressure terms and the output register
  res_t rs_res;

  sic_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .bk_valid (qo_valid),
    .bk_quot  (qo_quot),
    .bk_zero  (qo_zero),
    .bk_res   (qo_res),
    .cal      (cal),
    .rs_valid (out_valid),
    .rs_press (out_pressure_q24_8),
    .rs_res   (rs_res)
  );

  assign out_temperature_centi = rs_res.temp;
  assign out_humidity_q22_10   = rs_res.hum;

  // humidity is clamped before leaving
  `ASSERT_HOLDS(a_hum_range, clk, rst_n, out_valid |-> (out_humidity_q22_10 <= 17'd102400))
  // back pressure only while a result is waiting
  `ASSERT_HOLDS(a_stall_has_word, clk, rst_n, in_stall |-> out_valid)
  // a held pipeline keeps its output word
  `ASSERT_NEXT(a_stall_freeze, clk, rst_n, in_stall, $stable(out_temperature_centi))

endmodule
